/* hw/rtl/pcm_pkg.sv */
package pcm_pkg;

  localparam int unsigned TickW  = 11;
  localparam int unsigned CapW   = 16;
  localparam int unsigned StampW = 32;
  localparam int unsigned ProdW  = StampW + TickW;

  localparam logic [TickW-1:0] TICK_RESET = 11'd128;

  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_OVERFLOW = 2'd1,
    OP_CAPTURE  = 2'd2,
    OP_UNUSED   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

endpackage

/* hw/rtl/pwm_capture_measure.sv */
// Channel | Ports                                        | Direction
// --------+----------------------------------------------+----------
// in      | in_valid/in_ready, in_opcode, in_capture_value | sink
// out     | out_valid/out_ready, out_period_us, out_on_time_us,
//         | out_done_res, out_edge_falling, out_measuring  | source
// cfg     | cfg_wr_en, cfg_wr_data (tick time)           | sink
//
// One beat per cycle is sustained while out_ready stays high.
// The input register feeds the phase and timestamp update, whose state registers then
// feed the tick multiply into the output register.
// Synchronous active-low reset clears the valid flags and the measurement state and loads the tick time with 128.
// A stall at the output fills the two inner stages before in_ready drops.
module pwm_capture_measure (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_opcode,
  input  logic [pcm_pkg::CapW-1:0]      in_capture_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [pcm_pkg::StampW-1:0]    out_period_us,
  output logic [pcm_pkg::StampW-1:0]    out_on_time_us,
  output logic                          out_done_res,
  output logic                          out_edge_falling,
  output logic                          out_measuring,
  input  logic                          cfg_wr_en,
  input  logic [pcm_pkg::TickW-1:0]     cfg_wr_data
);
  import pcm_pkg::*;

  logic                a_valid_r;
  opcode_t             a_op_r;
  logic [CapW-1:0]     a_cap_r;
  logic                b_valid_r;
  logic                b_ready;
  logic                b_load;
  logic                c_ready;
  logic                c_load;

  logic [TickW-1:0]    tick_r;

  phase_t              phase_r, phase_nxt;
  logic [CapW-1:0]     wrap_r, wrap_nxt;
  logic [CapW-1:0]     first_r, first_nxt;
  logic [StampW-1:0]   second_r, second_nxt;
  logic [StampW-1:0]   period_raw_r, period_raw_nxt;
  logic [StampW-1:0]   on_raw_r, on_raw_nxt;
  logic                active_r, active_nxt;
  logic                done_r, done_nxt;
  logic [StampW-1:0]   ext_stamp;

  logic [ProdW-1:0]    period_prod;
  logic [ProdW-1:0]    on_prod;
  logic [StampW-1:0]   period_us_r;
  logic [StampW-1:0]   on_time_us_r;
  logic                done_out_r;
  logic                edge_out_r;
  logic                meas_out_r;
  logic                out_valid_r;

  assign c_ready  = !out_valid_r || out_ready;
  assign b_ready  = !b_valid_r || c_ready;
  assign in_ready = !a_valid_r || b_ready;
  assign b_load   = a_valid_r && b_ready;
  assign c_load   = b_valid_r && c_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r   <= 1'b0;
      b_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        a_valid_r <= 1'b1;
      end else if (b_ready) begin
        a_valid_r <= 1'b0;
      end
      if (b_load) begin
        b_valid_r <= 1'b1;
      end else if (c_ready) begin
        b_valid_r <= 1'b0;
      end
      if (c_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      a_op_r  <= opcode_t'(in_opcode);
      a_cap_r <= in_capture_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r <= TICK_RESET;
    end else if (cfg_wr_en) begin
      tick_r <= cfg_wr_data;
    end
  end

  assign ext_stamp = {wrap_r, a_cap_r};

  always_comb begin
    phase_nxt      = phase_r;
    wrap_nxt       = wrap_r;
    first_nxt      = first_r;
    second_nxt     = second_r;
    period_raw_nxt = period_raw_r;
    on_raw_nxt     = on_raw_r;
    active_nxt     = active_r;
    done_nxt       = 1'b0;
    unique case (a_op_r)
      OP_START: begin
        active_nxt     = 1'b1;
        phase_nxt      = PH_FIRST;
        wrap_nxt       = '0;
        period_raw_nxt = '0;
        on_raw_nxt     = '0;
      end
      OP_OVERFLOW: begin
        if (active_r) begin
          wrap_nxt = wrap_r + 1'b1;
        end
      end
      OP_CAPTURE: begin
        if (active_r) begin
          unique case (phase_r)
            PH_FIRST: begin
              wrap_nxt  = '0;
              first_nxt = a_cap_r;
              phase_nxt = PH_SECOND;
            end
            PH_SECOND: begin
              second_nxt     = ext_stamp;
              period_raw_nxt = ext_stamp - {{(StampW-CapW){1'b0}}, first_r};
              phase_nxt      = PH_THIRD;
            end
            default: begin
              on_raw_nxt = ext_stamp - second_r;
              done_nxt   = 1'b1;
              active_nxt = 1'b0;
              phase_nxt  = PH_FIRST;
              wrap_nxt   = '0;
            end
          endcase
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FIRST;
      wrap_r       <= '0;
      first_r      <= '0;
      second_r     <= '0;
      period_raw_r <= '0;
      on_raw_r     <= '0;
      active_r     <= 1'b0;
      done_r       <= 1'b0;
    end else if (b_load) begin
      phase_r      <= phase_nxt;
      wrap_r       <= wrap_nxt;
      first_r      <= first_nxt;
      second_r     <= second_nxt;
      period_raw_r <= period_raw_nxt;
      on_raw_r     <= on_raw_nxt;
      active_r     <= active_nxt;
      done_r       <= done_nxt;
    end
  end

  assign period_prod = {{TickW{1'b0}}, period_raw_r} * {{StampW{1'b0}}, tick_r};
  assign on_prod     = {{TickW{1'b0}}, on_raw_r} * {{StampW{1'b0}}, tick_r};

  always_ff @(posedge clk) begin
    if (c_load) begin
      period_us_r  <= period_prod[StampW-1:0];
      on_time_us_r <= on_prod[StampW-1:0];
      done_out_r   <= done_r;
      edge_out_r   <= active_r && (phase_r == PH_THIRD);
      meas_out_r   <= active_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_period_us    = period_us_r;
  assign out_on_time_us   = on_time_us_r;
  assign out_done_res     = done_out_r;
  assign out_edge_falling = edge_out_r;
  assign out_measuring    = meas_out_r;

endmodule

/* hw/rtl/pcm_checker.sv */
module pcm_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [pcm_pkg::StampW-1:0]    out_period_us,
  input logic [pcm_pkg::StampW-1:0]    out_on_time_us,
  input logic                          out_done_res,
  input logic                          out_edge_falling,
  input logic                          out_measuring
);
  import pcm_pkg::*;

  // A held result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_period_us) && $stable(out_on_time_us)
      && $stable(out_done_res) && $stable(out_edge_falling) && $stable(out_measuring))
    else $error("result payload changed while stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_measuring && !out_edge_falling)
    else $error("completed measurement still reports activity");

  a_edge_meas: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_edge_falling |-> out_measuring)
    else $error("falling edge armed while idle");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while no result is waiting");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind pwm_capture_measure pcm_checker u_pcm_checker (.*);

/* dv/pwm_capture_measure_tb.sv */
`timescale 1ns / 100ps

module pwm_capture_measure_tb;
  import pcm_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;

  typedef struct packed {
    logic [StampW-1:0] period_us;
    logic [StampW-1:0] on_time_us;
    logic              done_res;
    logic              edge_falling;
    logic              measuring;
  } meas_result_t;

  class pwm_meas_scoreboard;
    logic [TickW-1:0]  tick_us;
    phase_t            phase;
    logic [CapW-1:0]   wraps;
    logic [StampW-1:0] first_stamp;
    logic [StampW-1:0] second_stamp;
    logic [StampW-1:0] period_ticks;
    logic [StampW-1:0] on_ticks;
    bit                active;
    meas_result_t      expected_meas[$];
    int unsigned       mismatches;

    function new();
      tick_us      = TICK_RESET;
      phase        = PH_FIRST;
      wraps        = '0;
      first_stamp  = '0;
      second_stamp = '0;
      period_ticks = '0;
      on_ticks     = '0;
      active       = 1'b0;
      mismatches   = 0;
    endfunction

    // Returns 1 when the beat changed the measurement state.
    function bit note_event(opcode_t op, logic [CapW-1:0] cap);
      meas_result_t      nxt;
      logic [StampW-1:0] stamp;
      bit                changed;
      bit                done;
      changed = 1'b0;
      done    = 1'b0;
      stamp   = {wraps, cap};
      case (op)
        OP_START: begin
          active       = 1'b1;
          phase        = PH_FIRST;
          wraps        = '0;
          period_ticks = '0;
          on_ticks     = '0;
          changed      = 1'b1;
        end
        OP_OVERFLOW: begin
          if (active) begin
            wraps   = wraps + 1'b1;
            changed = 1'b1;
          end
        end
        OP_CAPTURE: begin
          if (active) begin
            changed = 1'b1;
            case (phase)
              PH_FIRST: begin
                wraps       = '0;
                first_stamp = {{(StampW-CapW){1'b0}}, cap};
                phase       = PH_SECOND;
              end
              PH_SECOND: begin
                second_stamp = stamp;
                period_ticks = stamp - first_stamp;
                phase        = PH_THIRD;
              end
              default: begin
                on_ticks = stamp - second_stamp;
                done     = 1'b1;
                active   = 1'b0;
                phase    = PH_FIRST;
                wraps    = '0;
              end
            endcase
          end
        end
        default: ;
      endcase
      nxt.period_us    = period_ticks * StampW'(tick_us);
      nxt.on_time_us   = on_ticks * StampW'(tick_us);
      nxt.done_res     = done;
      nxt.edge_falling = active && (phase == PH_THIRD);
      nxt.measuring    = active;
      expected_meas.push_back(nxt);
      return changed;
    endfunction

    function void compare_field(string name, logic [StampW-1:0] want, logic [StampW-1:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch on %s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_measurement(meas_result_t got);
      meas_result_t want;
      if (expected_meas.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Result beat with no pending expectation: %p", got);
        return;
      end
      want = expected_meas.pop_front();
      compare_field("period_us", want.period_us, got.period_us);
      compare_field("on_time_us", want.on_time_us, got.on_time_us);
      compare_field("done_res", StampW'(want.done_res), StampW'(got.done_res));
      compare_field("edge_falling", StampW'(want.edge_falling), StampW'(got.edge_falling));
      compare_field("measuring", StampW'(want.measuring), StampW'(got.measuring));
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [1:0]        in_opcode = OP_UNUSED;
  logic [CapW-1:0]   in_capture_value = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [StampW-1:0] out_period_us;
  logic [StampW-1:0] out_on_time_us;
  logic              out_done_res;
  logic              out_edge_falling;
  logic              out_measuring;
  logic              cfg_wr_en = 1'b0;
  logic [TickW-1:0]  cfg_wr_data = '0;

  pwm_meas_scoreboard sb;
  bit                 no_gaps = 1'b0;
  int unsigned        state_beats = 0;
  int unsigned        cycle_count = 0;

  pwm_capture_measure u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_capture_value (in_capture_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_period_us    (out_period_us),
    .out_on_time_us   (out_on_time_us),
    .out_done_res     (out_done_res),
    .out_edge_falling (out_edge_falling),
    .out_measuring    (out_measuring),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    forever begin
      @(negedge clk);
      out_ready <= no_gaps || ($urandom_range(0, 99) >= 13);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_measurement('{out_period_us, out_on_time_us, out_done_res,
                             out_edge_falling, out_measuring});
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [CapW-1:0] rand_cap();
    int unsigned pick;
    pick = $urandom_range(0, 7);
    if (pick == 0)
      return '0;
    if (pick == 1)
      return '1;
    return CapW'($urandom_range(0, 65535));
  endfunction

  task automatic send_beat(opcode_t op, logic [CapW-1:0] cap);
    int unsigned gap;
    if (!no_gaps && $urandom_range(0, 99) < 13) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_capture_value <= cap;
    do @(posedge clk); while (!in_ready);
    if (sb.note_event(op, cap))
      state_beats++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.expected_meas.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_tick(logic [TickW-1:0] val);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    sb.tick_us = val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_measurement();
    int unsigned n;
    send_beat(OP_START, rand_cap());
    for (int k = 0; k < 3; k++) begin
      n = $urandom_range(0, 3);
      repeat (n) begin
        if ($urandom_range(0, 99) < 5)
          send_beat(OP_UNUSED, rand_cap());
        else
          send_beat(OP_OVERFLOW, rand_cap());
      end
      send_beat(OP_CAPTURE, rand_cap());
    end
  endtask

  task automatic random_noise();
    int unsigned n;
    if ($urandom_range(0, 1) == 1)
      send_beat(OP_START, rand_cap());
    n = $urandom_range(1, 4);
    repeat (n) send_beat(opcode_t'($urandom_range(0, 3)), rand_cap());
  endtask

  task automatic run_phase(logic [TickW-1:0] tick, int unsigned target);
    int unsigned base;
    bit          paused;
    settle();
    write_tick(tick);
    base   = state_beats;
    paused = 1'b0;
    while (state_beats - base < target) begin
      if ($urandom_range(0, 99) < 80)
        random_measurement();
      else
        random_noise();
      if (!paused && state_beats - base >= target / 2) begin
        settle();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Idle beats are ignored; the reset tick value scales the first results.
    send_beat(OP_OVERFLOW, 16'h1234);
    send_beat(OP_CAPTURE, 16'hFFFF);
    send_beat(OP_UNUSED, 16'h0000);
    send_beat(OP_START, 16'h0000);
    send_beat(OP_OVERFLOW, 16'hFFFF);
    send_beat(OP_CAPTURE, 16'h0000);
    send_beat(OP_OVERFLOW, 16'h5555);
    send_beat(OP_OVERFLOW, 16'hAAAA);
    send_beat(OP_UNUSED, 16'hFFFF);
    send_beat(OP_CAPTURE, 16'hFFFF);
    // A start in the middle of a measurement restarts it.
    send_beat(OP_START, 16'h0000);
    send_beat(OP_CAPTURE, 16'hFFFF);
    send_beat(OP_OVERFLOW, 16'h0000);
    send_beat(OP_CAPTURE, 16'h0000);
    send_beat(OP_OVERFLOW, 16'h0000);
    send_beat(OP_CAPTURE, 16'hFFFF);
    send_beat(OP_CAPTURE, 16'h0001);
    send_beat(OP_OVERFLOW, 16'h0001);
    // Later timestamps below earlier ones wrap around 2^32.
    send_beat(OP_START, 16'hFFFF);
    send_beat(OP_CAPTURE, 16'd100);
    send_beat(OP_CAPTURE, 16'd50);
    send_beat(OP_CAPTURE, 16'd10);
    send_beat(OP_UNUSED, 16'hFFFF);

    // A long run of overflows between captures, with no idling anywhere.
    settle();
    write_tick(11'h7FF);
    no_gaps = 1'b1;
    send_beat(OP_START, rand_cap());
    send_beat(OP_CAPTURE, 16'd5);
    repeat (40) send_beat(OP_OVERFLOW, rand_cap());
    send_beat(OP_CAPTURE, 16'd3);
    send_beat(OP_OVERFLOW, rand_cap());
    send_beat(OP_OVERFLOW, rand_cap());
    send_beat(OP_CAPTURE, 16'd7);
    settle();
    no_gaps = 1'b0;

    run_phase(11'd1024, 90);
    run_phase(11'd1, 90);
    run_phase(11'd0, 80);
    run_phase(11'h7FF, 90);
    run_phase(TickW'($urandom_range(1, 1024)), 90);
    run_phase(TickW'($urandom_range(0, 2047)), 90);
    settle();

    if (sb.mismatches == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
